// ===== rtl/hsvc_pkg.sv =====
// hsvc_pkg: types and constants shared by the hsv to rgb converter pipeline
// no dependencies; imported by every hsvc module and by the top level
`default_nettype none

package hsvc_pkg;

	typedef struct packed {
		logic [8:0] hue_deg;
		logic [7:0] saturation;
		logic [7:0] brightness;
		logic [7:0] alpha_in;
	} hsv_pixel_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha_out;
	} rgb_pixel_t;

	// hue sectors, named after the colours they run between
	typedef enum logic [2:0] {
		SEC_RED_YEL,
		SEC_YEL_GRN,
		SEC_GRN_CYN,
		SEC_CYN_BLU,
		SEC_BLU_MAG,
		SEC_MAG_RED
	} sector_t;

	// side data that rides alongside the arithmetic
	typedef struct packed {
		sector_t    sector;
		logic       gray;
		logic [7:0] brightness;
		logic [7:0] alpha;
	} hsvc_ctrl_t;

	localparam int unsigned HUE_LIMIT  = 360;
	localparam int unsigned SECTOR_DEG = 60;
	// f = floor(rem * 256 / 60) = (rem * F_RECIP) >> F_SHIFT for rem 0..59
	localparam int unsigned F_RECIP    = 4370;
	localparam int unsigned F_SHIFT    = 10;
	localparam int unsigned DEN_P      = 255;
	localparam int unsigned HALF_P     = 127;
	localparam int unsigned DEN_QT     = 65280;
	localparam int unsigned HALF_QT    = 32640;
	localparam int unsigned F_FULL     = 256;

	// floor(x / 255), exact for x up to 65279 (the largest x whose quotient fits in 8 bits)
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] sum;
		sum = 17'(x) + 17'd1 + 17'(x[15:8]);
		return sum[15:8];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/hsvc_decode.sv =====
// hsvc_decode: first pipeline stage, hue of 360 or more forced to 0, sector and remainder within sector
// depends on hsvc_pkg
`default_nettype none

module hsvc_decode
	import hsvc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire hsv_pixel_t pix,
	output logic            valid_s1,
	output logic [5:0]      rem_s1,
	output logic [7:0]      sat_s1,
	output hsvc_ctrl_t      ctrl_s1
);

	logic [8:0] hue_c;
	logic [8:0] base_c;
	logic [8:0] diff_c;
	sector_t    sector_c;

	always_comb begin
		hue_c = (pix.hue_deg >= 9'(HUE_LIMIT)) ? 9'd0 : pix.hue_deg;
		if (hue_c >= 9'(SECTOR_DEG * 5)) begin
			sector_c = SEC_MAG_RED;
			base_c   = 9'(SECTOR_DEG * 5);
		end else if (hue_c >= 9'(SECTOR_DEG * 4)) begin
			sector_c = SEC_BLU_MAG;
			base_c   = 9'(SECTOR_DEG * 4);
		end else if (hue_c >= 9'(SECTOR_DEG * 3)) begin
			sector_c = SEC_CYN_BLU;
			base_c   = 9'(SECTOR_DEG * 3);
		end else if (hue_c >= 9'(SECTOR_DEG * 2)) begin
			sector_c = SEC_GRN_CYN;
			base_c   = 9'(SECTOR_DEG * 2);
		end else if (hue_c >= 9'(SECTOR_DEG)) begin
			sector_c = SEC_YEL_GRN;
			base_c   = 9'(SECTOR_DEG);
		end else begin
			sector_c = SEC_RED_YEL;
			base_c   = 9'd0;
		end
		diff_c = hue_c - base_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s1             <= diff_c[5:0];
		sat_s1             <= pix.saturation;
		ctrl_s1.sector     <= sector_c;
		ctrl_s1.gray       <= (pix.saturation == 8'd0);
		ctrl_s1.brightness <= pix.brightness;
		ctrl_s1.alpha      <= pix.alpha_in;
	end

endmodule

`default_nettype wire

// ===== rtl/hsvc_channel_calc.sv =====
// hsvc_channel_calc: stages two to five, works out p, q and t with rounded divides
// depends on hsvc_pkg
`default_nettype none

module hsvc_channel_calc
	import hsvc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       valid_s1,
	input  wire logic [5:0] rem_s1,
	input  wire logic [7:0] sat_s1,
	input  wire hsvc_ctrl_t ctrl_s1,
	output logic            valid_s5,
	output logic [7:0]      p_s5,
	output logic [7:0]      q_s5,
	output logic [7:0]      t_s5,
	output hsvc_ctrl_t      ctrl_s5
);

	// stage 2
	logic        valid_s2;
	logic [7:0]  f_s2;
	logic [15:0] pprod_s2;
	logic [7:0]  sat_s2;
	hsvc_ctrl_t  ctrl_s2;
	// stage 3
	logic        valid_s3;
	logic [15:0] nq_s3;
	logic [15:0] nt_s3;
	logic [7:0]  p_s3;
	hsvc_ctrl_t  ctrl_s3;
	// stage 4
	logic        valid_s4;
	logic [23:0] qprod_s4;
	logic [23:0] tprod_s4;
	logic [7:0]  p_s4;
	hsvc_ctrl_t  ctrl_s4;

	logic [18:0] fprod_c;
	logic [8:0]  fcomp_c;

	assign fprod_c = 19'(rem_s1) * 19'(F_RECIP);
	assign fcomp_c = 9'(F_FULL) - 9'(f_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		f_s2     <= fprod_c[F_SHIFT +: 8];
		pprod_s2 <= 16'(ctrl_s1.brightness) * (16'(DEN_P) - 16'(sat_s1));
		sat_s2   <= sat_s1;
		ctrl_s2  <= ctrl_s1;

		nq_s3   <= 16'(DEN_QT) - 16'(sat_s2) * 16'(f_s2);
		nt_s3   <= 16'(DEN_QT) - 16'(sat_s2) * 16'(fcomp_c);
		p_s3    <= div255(pprod_s2 + 16'(HALF_P));
		ctrl_s3 <= ctrl_s2;

		qprod_s4 <= 24'(ctrl_s3.brightness) * 24'(nq_s3) + 24'(HALF_QT);
		tprod_s4 <= 24'(ctrl_s3.brightness) * 24'(nt_s3) + 24'(HALF_QT);
		p_s4     <= p_s3;
		ctrl_s4  <= ctrl_s3;

		// divide by 65280 as a divide by 256 (dropping the low 8 bits) then a divide by 255
		q_s5    <= div255(qprod_s4[23:8]);
		t_s5    <= div255(tprod_s4[23:8]);
		p_s5    <= p_s4;
		ctrl_s5 <= ctrl_s4;
	end

endmodule

`default_nettype wire

// ===== rtl/hsv_to_rgb_converter.sv =====
// hsv_to_rgb_converter: one pixel per clock, result strobe done follows start through
// the valid_s1 to valid_s5 stage registers and then the done register; busy never rises,
// so a new item may be taken every cycle. reset clears only the stage valid bits and done.
// depends on hsvc_pkg, hsvc_decode, hsvc_channel_calc
`default_nettype none

module hsv_to_rgb_converter
	import hsvc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire hsv_pixel_t hsv,
	output logic            done,
	output rgb_pixel_t      rgb
);

	logic       valid_s1;
	logic [5:0] rem_s1;
	logic [7:0] sat_s1;
	hsvc_ctrl_t ctrl_s1;
	logic       valid_s5;
	logic [7:0] p_s5;
	logic [7:0] q_s5;
	logic [7:0] t_s5;
	hsvc_ctrl_t ctrl_s5;
	rgb_pixel_t rgb_c;

	assign busy = 1'b0;

	hsvc_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start & ~busy),
		.pix      (hsv),
		.valid_s1 (valid_s1),
		.rem_s1   (rem_s1),
		.sat_s1   (sat_s1),
		.ctrl_s1  (ctrl_s1)
	);

	hsvc_channel_calc u_calc (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.rem_s1   (rem_s1),
		.sat_s1   (sat_s1),
		.ctrl_s1  (ctrl_s1),
		.valid_s5 (valid_s5),
		.p_s5     (p_s5),
		.q_s5     (q_s5),
		.t_s5     (t_s5),
		.ctrl_s5  (ctrl_s5)
	);

	always_comb begin
		rgb_c.alpha_out = ctrl_s5.alpha;
		case (ctrl_s5.sector)
			SEC_RED_YEL: begin
				rgb_c.red = ctrl_s5.brightness; rgb_c.green = t_s5; rgb_c.blue = p_s5;
			end
			SEC_YEL_GRN: begin
				rgb_c.red = q_s5; rgb_c.green = ctrl_s5.brightness; rgb_c.blue = p_s5;
			end
			SEC_GRN_CYN: begin
				rgb_c.red = p_s5; rgb_c.green = ctrl_s5.brightness; rgb_c.blue = t_s5;
			end
			SEC_CYN_BLU: begin
				rgb_c.red = p_s5; rgb_c.green = q_s5; rgb_c.blue = ctrl_s5.brightness;
			end
			SEC_BLU_MAG: begin
				rgb_c.red = t_s5; rgb_c.green = p_s5; rgb_c.blue = ctrl_s5.brightness;
			end
			default: begin
				rgb_c.red = ctrl_s5.brightness; rgb_c.green = p_s5; rgb_c.blue = q_s5;
			end
		endcase
		// zero saturation gives gray
		if (ctrl_s5.gray) begin
			rgb_c.red   = ctrl_s5.brightness;
			rgb_c.green = ctrl_s5.brightness;
			rgb_c.blue  = ctrl_s5.brightness;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		rgb <= rgb_c;
	end

endmodule

`default_nettype wire
